// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl files
// no dependencies; include once per file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define DAP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define DAP_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/dap_pkg.sv =====
// constants, character codes and the power-of-ten table for the amount parser
// no dependencies
package dap_pkg;

    localparam int AMOUNT_W   = 63;
    localparam int CHAR_W     = 8;
    localparam int PLACES_W   = 4;
    localparam int SCALE_W    = 27;   // holds 10^8
    localparam int DIGIT_W    = 4;

    localparam logic [PLACES_W-1:0] PLACES_MAX   = 4'd8;
    localparam logic [PLACES_W-1:0] PLACES_RESET = 4'd8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    function automatic logic [SCALE_W-1:0] pow_ten(input logic [PLACES_W-1:0] exp);
        logic [SCALE_W-1:0] r;
        case (exp)
            4'd0:    r = 27'd1;
            4'd1:    r = 27'd10;
            4'd2:    r = 27'd100;
            4'd3:    r = 27'd1000;
            4'd4:    r = 27'd10000;
            4'd5:    r = 27'd100000;
            4'd6:    r = 27'd1000000;
            4'd7:    r = 27'd10000000;
            4'd8:    r = 27'd100000000;
            default: r = 27'd100000000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/decimal_amount_parser_core.sv =====
// streaming ascii amount parser, top level
// depends on dap_pkg and assert_macros.svh
`include "assert_macros.svh"

// Usage:
//   s_valid/s_ready carry one ascii character per request (s_char_code) and
//   s_last_char marks the end of a string. Characters of a string update the
//   digit accumulator in the cycle they are accepted, one character per cycle while s_ready is high.
//   The request marked last produces exactly one result on m_valid/m_ready:
//   m_amount, the value scaled by 10^decimal_places, or 0 when the text was
//   invalid or the value overflowed 63 bits. Other requests produce nothing.
//   Result path: the edge that accepts the last character loads stage 1
//   (final value and scale), stage 2 forms a 63x27 multiply split into two
//   partial products, then the add with overflow check is registered into m_amount.
//   Throughput: one character per cycle while s_ready is high, also back to back across strings.
//   The receiver may stall: results queue in the two pipeline stages and the
//   output register, and s_ready drops only when all three are full.
//   cfg_we writes decimal_places from cfg_wdata; write it only
//   while the block is idle. Values above 8 act as 8.
//   Reset (aresetn low, synchronous) empties the pipeline, starts a new string
//   and sets decimal_places to 8.
module decimal_amount_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dap_pkg::CHAR_W-1:0]    s_char_code,
    input  logic                          s_last_char,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dap_pkg::AMOUNT_W-1:0]  m_amount,
    input  logic                          cfg_we,
    input  logic [dap_pkg::PLACES_W-1:0]  cfg_wdata
);
    import dap_pkg::*;

    localparam int WIDE_W = AMOUNT_W + 4;
    localparam int LO_W   = 32;
    localparam int HI_W   = AMOUNT_W - LO_W;
    localparam int PLO_W  = LO_W + SCALE_W;
    localparam int PHI_W  = HI_W + SCALE_W;
    localparam int SUM_W  = AMOUNT_W + SCALE_W;

    // configuration
    logic [PLACES_W-1:0] places_reg;

    // string state
    logic [AMOUNT_W-1:0] acc_reg,      acc_next;
    logic                seen_dot_reg, seen_dot_next;
    logic [PLACES_W-1:0] frac_reg,     frac_next;
    logic                rej_reg,      rej_next;
    logic                start_reg,    start_next;

    // stage 1: final value and scale
    logic                p1_valid_reg;
    logic [AMOUNT_W-1:0] p1_acc_reg;
    logic [SCALE_W-1:0]  p1_scale_reg;
    logic                p1_zero_reg;

    // stage 2: partial products
    logic                p2_valid_reg;
    logic [PLO_W-1:0]    p2_lo_reg;
    logic [PHI_W-1:0]    p2_hi_reg;
    logic                p2_zero_reg;

    // output register
    logic                m_valid_reg;
    logic [AMOUNT_W-1:0] m_amount_reg;

    logic                accept;
    logic                out_free, p2_free, p1_free;
    logic [PLACES_W-1:0] places;
    logic [DIGIT_W-1:0]  digit;
    logic [WIDE_W-1:0]   acc_x10;
    logic                is_digit;
    logic                p1_zero_next;
    logic [SUM_W-1:0]    sum;
    logic                sum_ovf;

    assign out_free = !m_valid_reg || m_ready;
    assign p2_free  = !p2_valid_reg || out_free;
    assign p1_free  = !p1_valid_reg || p2_free;
    assign s_ready  = p1_free;
    assign accept   = s_valid && s_ready;

    assign places   = (places_reg > PLACES_MAX) ? PLACES_MAX : places_reg;
    assign digit    = DIGIT_W'(s_char_code - CHAR_ZERO);
    assign is_digit = s_char_code inside {[CHAR_ZERO:CHAR_NINE]};
    assign acc_x10  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                      + WIDE_W'(digit);

    always_comb begin
        acc_next      = acc_reg;
        seen_dot_next = seen_dot_reg;
        frac_next     = frac_reg;
        rej_next      = rej_reg;
        start_next    = 1'b0;
        if (!rej_reg) begin
            if (s_char_code == CHAR_MINUS) begin
                rej_next = 1'b1;
            end else if (places == '0 && seen_dot_reg) begin
                // ignored tail with zero places
                rej_next = rej_reg;
            end else if (s_char_code == CHAR_PLUS) begin
                if (!start_reg) begin
                    rej_next = 1'b1;
                end
            end else if (s_char_code == CHAR_DOT) begin
                if (places != '0 && seen_dot_reg) begin
                    rej_next = 1'b1;
                end
                seen_dot_next = 1'b1;
            end else if (!is_digit) begin
                rej_next = 1'b1;
            end else if (seen_dot_reg && frac_reg >= places) begin
                rej_next = 1'b1;
            end else begin
                if (seen_dot_reg) begin
                    frac_next = frac_reg + 1'b1;
                end
                if (|acc_x10[WIDE_W-1:AMOUNT_W]) begin
                    rej_next = 1'b1;
                end else begin
                    acc_next = acc_x10[AMOUNT_W-1:0];
                end
            end
        end
    end

    assign p1_zero_next = rej_next || (frac_next > places);

    // string state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            places_reg   <= PLACES_RESET;
            acc_reg      <= '0;
            seen_dot_reg <= 1'b0;
            frac_reg     <= '0;
            rej_reg      <= 1'b0;
            start_reg    <= 1'b1;
        end else begin
            if (cfg_we) begin
                places_reg <= cfg_wdata;
            end
            if (accept) begin
                if (s_last_char) begin
                    acc_reg      <= '0;
                    seen_dot_reg <= 1'b0;
                    frac_reg     <= '0;
                    rej_reg      <= 1'b0;
                    start_reg    <= 1'b1;
                end else begin
                    acc_reg      <= acc_next;
                    seen_dot_reg <= seen_dot_next;
                    frac_reg     <= frac_next;
                    rej_reg      <= rej_next;
                    start_reg    <= start_next;
                end
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (p1_free) begin
                p1_valid_reg <= accept && s_last_char;
            end
            if (p2_free) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= p2_valid_reg;
            end
        end
    end

    assign sum     = {p2_hi_reg, {LO_W{1'b0}}} + SUM_W'(p2_lo_reg);
    assign sum_ovf = |sum[SUM_W-1:AMOUNT_W];

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (p1_free && accept && s_last_char) begin
            p1_acc_reg   <= acc_next;
            p1_zero_reg  <= p1_zero_next;
            // index is only meaningful when the count is within places
            p1_scale_reg <= pow_ten(places - frac_next);
        end
        if (p2_free && p1_valid_reg) begin
            p2_lo_reg   <= PLO_W'(p1_acc_reg[LO_W-1:0]) * PLO_W'(p1_scale_reg);
            p2_hi_reg   <= PHI_W'(p1_acc_reg[AMOUNT_W-1:LO_W]) * PHI_W'(p1_scale_reg);
            p2_zero_reg <= p1_zero_reg;
        end
        if (out_free && p2_valid_reg) begin
            m_amount_reg <= (p2_zero_reg || sum_ovf) ? '0 : sum[AMOUNT_W-1:0];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_amount = m_amount_reg;

    `DAP_ASSERT(a_last_restarts, aclk, aresetn, (accept && s_last_char) |=> (start_reg && acc_reg == '0 && !seen_dot_reg && !rej_reg && frac_reg == '0), "state not cleared after last character")
    `DAP_ASSERT(a_frac_needs_dot, aclk, aresetn, !seen_dot_reg |-> (frac_reg == '0), "fraction digits counted without a dot")
    `DAP_NEVER(a_stall_only_full, aclk, aresetn, !s_ready && !(p1_valid_reg && p2_valid_reg && m_valid_reg), "input stalled with a free stage")

endmodule

// ===== verif/dap_amount_checker.sv =====
`timescale 1ns / 1ps
// request/result checker for decimal_amount_parser_core: predicts each amount
// from the accepted characters and compares it on the result channel
// depends on dap_pkg
module dap_amount_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [dap_pkg::CHAR_W-1:0]    s_char_code,
    input  logic                          s_last_char,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [dap_pkg::AMOUNT_W-1:0]  m_amount,
    input  logic                          cfg_we,
    input  logic [dap_pkg::PLACES_W-1:0]  cfg_wdata,
    output int unsigned                   fail_count,
    output int unsigned                   amounts_waiting
);
    import dap_pkg::*;

    localparam logic [AMOUNT_W-1:0] AMOUNT_LIMIT = {AMOUNT_W{1'b1}};

    logic [PLACES_W-1:0] places_reg;
    logic [AMOUNT_W-1:0] digits_acc;
    logic                dot_seen;
    logic [PLACES_W-1:0] fraction_digits;
    logic                string_bad;
    logic                at_first;
    logic [AMOUNT_W-1:0] amount_due;
    logic [AMOUNT_W-1:0] expected_amounts[$];

    function automatic logic [PLACES_W-1:0] active_places();
        return (places_reg > PLACES_MAX) ? PLACES_MAX : places_reg;
    endfunction

    function automatic logic [AMOUNT_W-1:0] decimal_scale(input logic [PLACES_W-1:0] n);
        logic [AMOUNT_W-1:0] s;
        s = 1;
        repeat (n) s = s * 10;
        return s;
    endfunction

    task automatic restart_string();
        digits_acc      = '0;
        dot_seen        = 1'b0;
        fraction_digits = '0;
        string_bad      = 1'b0;
        at_first        = 1'b1;
    endtask

    task automatic take_char(input logic [CHAR_W-1:0] c);
        logic [PLACES_W-1:0] pl;
        logic                first;
        logic [AMOUNT_W-1:0] d;
        pl       = active_places();
        first    = at_first;
        at_first = 1'b0;
        if (!string_bad) begin
            if (c == CHAR_MINUS) begin
                string_bad = 1'b1;
            end else if (pl == 0 && dot_seen) begin
                // zero places: the tail after the dot is dropped
                string_bad = 1'b0;
            end else if (c == CHAR_PLUS) begin
                if (!first) string_bad = 1'b1;
            end else if (c == CHAR_DOT) begin
                if (pl != 0 && dot_seen) string_bad = 1'b1;
                dot_seen = 1'b1;
            end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
                string_bad = 1'b1;
            end else if (dot_seen && fraction_digits >= pl) begin
                string_bad = 1'b1;
            end else begin
                if (dot_seen) fraction_digits = fraction_digits + 1'b1;
                d = c - CHAR_ZERO;
                if (digits_acc > (AMOUNT_LIMIT - d) / 10) string_bad = 1'b1;
                else digits_acc = digits_acc * 10 + d;
            end
        end
    endtask

    // zero padding of the fraction, with its own overflow check
    function automatic logic [AMOUNT_W-1:0] closing_amount();
        logic [PLACES_W-1:0] pl;
        logic [AMOUNT_W-1:0] scale;
        pl = active_places();
        if (string_bad || fraction_digits > pl) return '0;
        scale = decimal_scale(pl - fraction_digits);
        if (digits_acc > AMOUNT_LIMIT / scale) return '0;
        return digits_acc * scale;
    endfunction

    initial begin
        fail_count      = 0;
        amounts_waiting = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            places_reg = PLACES_RESET;
            restart_string();
            expected_amounts.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_amounts.size() == 0) begin
                    fail_count++;
                    $error("amount: no result expected, actual %0d", m_amount);
                end else begin
                    amount_due = expected_amounts.pop_front();
                    if (m_amount !== amount_due) begin
                        fail_count++;
                        $error("amount mismatch: expected %0d, actual %0d", amount_due, m_amount);
                    end
                end
            end
            if (s_valid && s_ready) begin
                take_char(s_char_code);
                if (s_last_char) begin
                    expected_amounts.push_back(closing_amount());
                    restart_string();
                end
            end
            if (cfg_we) places_reg = cfg_wdata;
        end
        amounts_waiting = expected_amounts.size();
    end

endmodule

// ===== verif/tb_decimal_amount_parser_core.sv =====
`timescale 1ns / 1ps
// testbench top for decimal_amount_parser_core: clock, reset, character
// stimulus, receiver stalls and verdict
// depends on dap_pkg, the parser rtl and dap_amount_checker
module tb_decimal_amount_parser_core;
    import dap_pkg::*;

    localparam int unsigned CHAR_TARGET   = 1600;
    localparam int unsigned PHASE_CHARS   = 200;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned LONG_HOLD     = 150;
    // slowest run: every request waits the longest gap and every result the
    // longest stall; this limit lies well above that
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CHAR_W-1:0]   s_char_code;
    logic                s_last_char;
    logic                m_valid;
    logic                m_ready;
    logic [AMOUNT_W-1:0] m_amount;
    logic                cfg_we;
    logic [PLACES_W-1:0] cfg_wdata;

    int unsigned         fail_count;
    int unsigned         amounts_waiting;
    int unsigned         chars_sent;
    int unsigned         cycle_count;
    logic [PLACES_W-1:0] cur_places;
    logic [CHAR_W-1:0]   amount_text[$];
    bit                  sender_steady;
    bit                  receiver_steady;
    bit                  long_hold_req;

    decimal_amount_parser_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_amount    (m_amount),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    dap_amount_checker amount_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_last_char     (s_last_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_amount        (m_amount),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .amounts_waiting (amounts_waiting)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned idle_cycles(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAR_W-1:0] any_digit();
        logic [CHAR_W-1:0] c;
        c = CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] odd_char();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 3))
            0: c = CHAR_MINUS;
            1: c = CHAR_PLUS;
            2: c = CHAR_DOT;
            default: c = CHAR_W'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input bit ends);
        int unsigned gap;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_last_char <= ends;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        gap = idle_cycles(sender_steady);
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_word(input string word, input bit ends);
        int i;
        for (i = 0; i < word.len(); i++) send_char(word[i], ends && (i == word.len() - 1));
    endtask

    task automatic send_amount_text();
        int i;
        for (i = 0; i < amount_text.size(); i++)
            send_char(amount_text[i], i == amount_text.size() - 1);
    endtask

    // wait for every result, then for the pipeline to settle
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (amounts_waiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_places(input logic [PLACES_W-1:0] v);
        quiesce();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_places = v;
    endtask

    task automatic compose_amount_text();
        int unsigned       kind;
        int unsigned       n_int;
        int unsigned       n_frac;
        int unsigned       pe;
        int unsigned       k;
        int unsigned       pos;
        logic [63:0]       near;
        logic [CHAR_W-1:0] c;
        amount_text.delete();
        pe   = (cur_places > PLACES_MAX) ? PLACES_MAX : cur_places;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            // integer right around the largest one that still scales
            near = {1'b0, {AMOUNT_W{1'b1}}};
            for (k = 0; k < pe; k++) near = near / 10;
            near = near - 5 + $urandom_range(0, 10);
            do begin
                c = CHAR_ZERO + CHAR_W'(near % 10);
                amount_text.push_front(c);
                near = near / 10;
            end while (near != 0);
        end else if (kind < 85) begin
            if ($urandom_range(0, 3) == 0) amount_text.push_back(CHAR_PLUS);
            k = $urandom_range(0, 99);
            n_int = (k < 80) ? $urandom_range(0, 5) :
                    (k < 95) ? $urandom_range(6, 14) : $urandom_range(15, 20);
            repeat (n_int) amount_text.push_back(any_digit());
            if ($urandom_range(0, 2) != 0) begin
                amount_text.push_back(CHAR_DOT);
                n_frac = $urandom_range(0, pe);
                if ($urandom_range(0, 9) == 0) n_frac = pe + 1;
                repeat (n_frac) amount_text.push_back(any_digit());
            end
            if (amount_text.size() == 0) amount_text.push_back(any_digit());
            // broken amount: one character swapped for a sign, dot or any byte
            if (kind >= 70) begin
                pos = $urandom_range(0, amount_text.size() - 1);
                amount_text[pos] = odd_char();
            end
        end else begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 1) == 0) amount_text.push_back(odd_char());
                else amount_text.push_back(any_digit());
            end
        end
    endtask

    // receiver: random stalls, steady stretches, and a long hold on request
    initial begin
        int unsigned hold;
        int unsigned span;
        m_ready         = 1'b0;
        receiver_steady = 1'b0;
        hold            = 0;
        span            = 0;
        forever begin
            @(negedge aclk);
            if (span == 0) begin
                receiver_steady = ($urandom_range(0, 3) == 0);
                span            = $urandom_range(20, 200);
            end else begin
                span--;
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold          = LONG_HOLD;
                m_ready      <= 1'b0;
            end else if (hold != 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (!receiver_steady && $urandom_range(0, 2) == 0) begin
                hold     = idle_cycles(1'b0);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk) cycle_count++;
        $display("** decimal_amount_parser_core: FAILED **");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned phase_end;
        s_valid       = 1'b0;
        s_char_code   = '0;
        s_last_char   = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        aresetn       = 1'b0;
        long_hold_req = 1'b0;
        sender_steady = 1'b0;
        chars_sent    = 0;
        cur_places    = PLACES_RESET;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed amounts, first at the reset scaling of eight places
        send_word("+9.25", 1'b1);
        send_word("1..", 1'b1);
        send_word("4-", 1'b1);
        send_word("5+", 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        set_places(4'd2);
        send_word(".123", 1'b1);
        // scaling changed in the middle of a string
        send_word("6", 1'b0);
        set_places(4'd0);
        send_word(".z", 1'b1);
        send_word(".5", 1'b1);
        send_word("3.-", 1'b1);

        phase = 0;
        while (chars_sent < CHAR_TARGET) begin
            case (phase)
                0: set_places(4'd15);
                1: set_places(4'd0);
                2: set_places(PLACES_MAX);
                3: set_places(4'd1);
                default: set_places(PLACES_W'($urandom_range(0, 15)));
            endcase
            if (phase == 1 || phase == 4) begin
                // hold the receiver off and send enough strings for the input to stall
                long_hold_req = 1'b1;
                sender_steady = 1'b1;
                repeat (24) send_char(CHAR_ZERO + 8'd7, 1'b1);
                sender_steady = 1'b0;
            end
            phase_end = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end && chars_sent < CHAR_TARGET) begin
                if ($urandom_range(0, 7) == 0) sender_steady = !sender_steady;
                compose_amount_text();
                send_amount_text();
            end
            phase++;
        end

        quiesce();
        if (fail_count == 0) begin
            $display("** decimal_amount_parser_core: PASSED **");
        end else begin
            $display("** decimal_amount_parser_core: FAILED **");
        end
        $finish;
    end

endmodule
